FILE: sv/tour_length_evaluator_macros.svh
// Assertion helpers for the tour length evaluator.
`ifndef TOUR_LENGTH_EVALUATOR_MACROS_SVH
`define TOUR_LENGTH_EVALUATOR_MACROS_SVH

`ifndef SYNTHESIS
// Checked on i_clk, off while i_rst_n is low.
`define TLE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Checked on i_clk, also during reset.
`define TLE_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define TLE_ASSERT(lbl, prop, msg)
`define TLE_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: sv/tle_pkg.sv
package tle_pkg;

    localparam int unsigned MAX_CITIES_DEF  = 16;
    localparam int unsigned COORD_BITS_DEF  = 8;
    localparam int unsigned FRAC_BITS_DEF   = 8;
    localparam int unsigned CMD_DEPTH_DEF   = 4;

    localparam int unsigned CITY_W   = 4;
    localparam int unsigned COORD_W  = 8;
    localparam int unsigned LEN_W    = 21;
    localparam int unsigned LEGS_W   = 5;

    localparam logic [LEN_W-1:0]  SUM_MAX  = '1;
    localparam logic [LEGS_W-1:0] LEGS_MAX = '1;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_TOUR = 1'b1;

    typedef struct packed {
        logic first;
        logic last;
    } t_leg_flags;

endpackage

FILE: sv/tle_queue.sv
module tle_queue #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: sv/tle_front.sv
module tle_front #(
    parameter int unsigned MAX_CITIES = 16,
    parameter int unsigned COORD_BITS = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    output logic                          o_full,
    input  logic                          i_mode,
    input  logic [tle_pkg::CITY_W-1:0]    i_city,
    input  logic [tle_pkg::COORD_W-1:0]   i_coord_x,
    input  logic [tle_pkg::COORD_W-1:0]   i_coord_y,
    input  logic                          i_first_city,
    input  logic                          i_last_city,
    output logic                          o_cmd_push,
    input  logic                          i_cmd_full,
    output tle_pkg::t_leg_flags           o_cmd_flags,
    output logic [COORD_BITS-1:0]         o_cmd_dx,
    output logic [COORD_BITS-1:0]         o_cmd_dy
);
    import tle_pkg::*;

    localparam int unsigned IDX_W = $clog2(MAX_CITIES);

    logic [COORD_BITS-1:0] r_mem_x [MAX_CITIES];
    logic [COORD_BITS-1:0] r_mem_y [MAX_CITIES];

    logic                  r_rd_vld;
    t_leg_flags            r_rd_flags;
    logic [COORD_BITS-1:0] r_rd_x;
    logic [COORD_BITS-1:0] r_rd_y;
    logic [COORD_BITS-1:0] r_prev_x;
    logic [COORD_BITS-1:0] r_prev_y;

    logic [CITY_W-1:0]     city_mod;
    logic [IDX_W-1:0]      idx;
    logic [COORD_BITS-1:0] cx;
    logic [COORD_BITS-1:0] cy;
    logic                  accept;

    // city index wraps at MAX_CITIES; at most eight subtracts for a 4-bit index
    always_comb begin
        city_mod = i_city;
        for (int k = 0; k < 8; k++) begin
            if (32'(city_mod) >= MAX_CITIES) begin
                city_mod = city_mod - CITY_W'(MAX_CITIES);
            end
        end
    end

    assign idx    = IDX_W'(city_mod);
    assign cx     = COORD_BITS'(i_coord_x);
    assign cy     = COORD_BITS'(i_coord_y);
    assign o_full = r_rd_vld && i_cmd_full;
    assign accept = i_push && !o_full;

    assign o_cmd_push  = r_rd_vld && !i_cmd_full;
    assign o_cmd_flags = r_rd_flags;
    assign o_cmd_dx    = (r_rd_x >= r_prev_x) ? r_rd_x - r_prev_x : r_prev_x - r_rd_x;
    assign o_cmd_dy    = (r_rd_y >= r_prev_y) ? r_rd_y - r_prev_y : r_prev_y - r_rd_y;

    // coordinate table, read data registered
    always_ff @(posedge i_clk) begin
        if (accept && i_mode == MODE_LOAD) begin
            r_mem_x[idx] <= cx;
            r_mem_y[idx] <= cy;
        end
        if (accept && i_mode == MODE_TOUR) begin
            r_rd_x           <= r_mem_x[idx];
            r_rd_y           <= r_mem_y[idx];
            r_rd_flags.first <= i_first_city;
            r_rd_flags.last  <= i_last_city;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
            r_prev_x <= '0;
            r_prev_y <= '0;
        end else begin
            if (accept && i_mode == MODE_TOUR) begin
                r_rd_vld <= 1'b1;
            end else if (o_cmd_push) begin
                r_rd_vld <= 1'b0;
            end
            if (o_cmd_push) begin
                r_prev_x <= r_rd_x;
                r_prev_y <= r_rd_y;
            end
        end
    end

endmodule

FILE: sv/tle_back.sv
module tle_back #(
    parameter int unsigned COORD_BITS = 8,
    parameter int unsigned FRAC_BITS  = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cmd_empty,
    input  tle_pkg::t_leg_flags          i_cmd_flags,
    input  logic [COORD_BITS-1:0]        i_cmd_dx,
    input  logic [COORD_BITS-1:0]        i_cmd_dy,
    output logic                         o_cmd_pop,
    input  logic                         i_pop,
    output logic                         o_empty,
    output logic [tle_pkg::LEN_W-1:0]    o_tour_length,
    output logic [tle_pkg::LEGS_W-1:0]   o_leg_count
);
    import tle_pkg::*;

    `include "tour_length_evaluator_macros.svh"

    localparam int unsigned RAD_W      = 2 * COORD_BITS + 2;
    localparam int unsigned ROOT_STEPS = COORD_BITS + 1 + FRAC_BITS;
    localparam int unsigned ROOT_W     = ROOT_STEPS;
    localparam int unsigned REM_W      = ROOT_W + 2;
    localparam int unsigned ST_W       = $clog2(ROOT_STEPS);
    localparam int unsigned ACC_W      = ((ROOT_W > LEN_W) ? ROOT_W : LEN_W) + 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQX,
        ST_SQY,
        ST_ROOT,
        ST_ACC
    } t_state;

    t_state                  r_state;
    t_leg_flags              r_flags;
    logic [COORD_BITS-1:0]   r_dx;
    logic [COORD_BITS-1:0]   r_dy;
    logic [RAD_W-1:0]        r_rad;
    logic [ROOT_W-1:0]       r_root;
    logic [REM_W-1:0]        r_rem;
    logic [ST_W-1:0]         r_step;
    logic [LEN_W-1:0]        r_sum;
    logic [LEGS_W-1:0]       r_legs;
    logic                    r_out_vld;
    logic [LEN_W-1:0]        r_out_len;
    logic [LEGS_W-1:0]       r_out_legs;

    logic [COORD_BITS-1:0]   mul_a;
    logic [2*COORD_BITS-1:0] prod;
    logic [REM_W-1:0]        rem_sh;
    logic [REM_W-1:0]        trial;
    logic                    ge;
    logic [ACC_W-1:0]        acc;
    logic [LEN_W-1:0]        n_sum;
    logic [LEGS_W-1:0]       n_legs;
    logic                    out_busy;
    logic                    finish;

    assign o_cmd_pop     = (r_state == ST_IDLE) && !i_cmd_empty;
    assign o_empty       = !r_out_vld;
    assign o_tour_length = r_out_len;
    assign o_leg_count   = r_out_legs;

    assign mul_a = (r_state == ST_SQX) ? r_dx : r_dy;
    assign prod  = mul_a * mul_a;

    // restoring square root, one radicand bit pair per cycle
    assign rem_sh = {r_rem[REM_W-3:0], r_rad[RAD_W-1 -: 2]};
    assign trial  = {r_root, 2'b01};
    assign ge     = (rem_sh >= trial);

    assign acc      = ACC_W'(r_sum) + ACC_W'(r_root);
    assign out_busy = r_out_vld && !i_pop;
    assign finish   = (r_state == ST_ACC) && (!r_flags.last || !out_busy);

    always_comb begin
        if (r_flags.first) begin
            n_sum  = '0;
            n_legs = '0;
        end else begin
            n_sum  = (acc > ACC_W'(SUM_MAX)) ? SUM_MAX : LEN_W'(acc);
            n_legs = (r_legs == LEGS_MAX) ? r_legs : r_legs + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_sum     <= '0;
            r_legs    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            // a new result may replace one popped in the same cycle
            if (finish && r_flags.last) begin
                r_out_vld <= 1'b1;
            end else if (i_pop && r_out_vld) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (!i_cmd_empty) begin
                        r_flags <= i_cmd_flags;
                        r_dx    <= i_cmd_dx;
                        r_dy    <= i_cmd_dy;
                        r_state <= i_cmd_flags.first ? ST_ACC : ST_SQX;
                    end
                end
                ST_SQX: begin
                    r_rad   <= RAD_W'(prod);
                    r_state <= ST_SQY;
                end
                ST_SQY: begin
                    r_rad   <= r_rad + RAD_W'(prod);
                    r_root  <= '0;
                    r_rem   <= '0;
                    r_step  <= ST_W'(ROOT_STEPS - 1);
                    r_state <= ST_ROOT;
                end
                ST_ROOT: begin
                    r_rad  <= r_rad << 2;
                    r_rem  <= ge ? rem_sh - trial : rem_sh;
                    r_root <= {r_root[ROOT_W-2:0], ge};
                    r_step <= r_step - 1'b1;
                    if (r_step == '0) begin
                        r_state <= ST_ACC;
                    end
                end
                ST_ACC: begin
                    if (finish) begin
                        r_sum   <= n_sum;
                        r_legs  <= n_legs;
                        r_state <= ST_IDLE;
                        if (r_flags.last) begin
                            r_out_len  <= n_sum;
                            r_out_legs <= n_legs;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    `TLE_ASSERT(a_rem_bound, (r_state == ST_ROOT) |-> (r_rem <= {r_root, 1'b0}), "sqrt remainder")
    `TLE_ASSERT(a_first_clears, finish && r_flags.first |=> {r_sum, r_legs} == '0, "not cleared")
    `TLE_ASSERT(a_sum_grows, finish && !r_flags.first |=> r_sum >= $past(r_sum), "sum shrank")
    `TLE_ASSERT(a_legs_grow, finish && !r_flags.first |=> r_legs >= $past(r_legs), "legs shrank")
    `TLE_ASSERT(a_res_load, finish && r_flags.last |=> r_out_vld && r_out_len == r_sum, "no result")

endmodule

FILE: sv/tour_length_evaluator.sv
// Tour length evaluator. Load items (mode 0) write one city's coordinates into a
// MAX_CITIES-entry table; tour items (mode 1) name cities in visiting order. A tour
// item flagged first_city clears the sum and leg count; every other tour item adds
// the truncated Euclidean distance to the previous tour city, FRAC_BITS fraction
// bits, into a saturating 21-bit sum. A tour item flagged last_city produces one
// result (sum and leg count) after its own leg. A city must be loaded before a tour
// names it. A tour leg passes through the distance engine in order: squaring of dx
// and then dy on one shared multiplier, the bit-pair square root, then the
// accumulate step and a return to idle to take the next leg; a first-city item goes
// from idle straight to accumulate. The front end reads the table and forms the
// coordinate deltas, and a CMD_DEPTH-entry queue lets it keep accepting while legs
// are being measured.
module tour_length_evaluator #(
    parameter int unsigned MAX_CITIES = tle_pkg::MAX_CITIES_DEF,
    parameter int unsigned COORD_BITS = tle_pkg::COORD_BITS_DEF,
    parameter int unsigned FRAC_BITS  = tle_pkg::FRAC_BITS_DEF,
    parameter int unsigned CMD_DEPTH  = tle_pkg::CMD_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic                         i_mode,
    input  logic [tle_pkg::CITY_W-1:0]   i_city,
    input  logic [tle_pkg::COORD_W-1:0]  i_coord_x,
    input  logic [tle_pkg::COORD_W-1:0]  i_coord_y,
    input  logic                         i_first_city,
    input  logic                         i_last_city,
    output logic                         empty,
    input  logic                         pop,
    output logic [tle_pkg::LEN_W-1:0]    o_tour_length,
    output logic [tle_pkg::LEGS_W-1:0]   o_leg_count
);
    import tle_pkg::*;

    localparam int unsigned FLAGS_W = $bits(t_leg_flags);
    localparam int unsigned CMD_W   = FLAGS_W + 2 * COORD_BITS;

    logic                  cmd_push;
    logic                  cmd_full;
    logic                  cmd_pop;
    logic                  cmd_empty;
    t_leg_flags            fr_flags;
    logic [COORD_BITS-1:0] fr_dx;
    logic [COORD_BITS-1:0] fr_dy;
    logic [CMD_W-1:0]      q_in;
    logic [CMD_W-1:0]      q_out;
    t_leg_flags            bk_flags;
    logic [COORD_BITS-1:0] bk_dx;
    logic [COORD_BITS-1:0] bk_dy;

    assign q_in = {fr_flags, fr_dx, fr_dy};
    assign {bk_flags, bk_dx, bk_dy} = q_out;

    tle_front #(
        .MAX_CITIES (MAX_CITIES),
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_mode       (i_mode),
        .i_city       (i_city),
        .i_coord_x    (i_coord_x),
        .i_coord_y    (i_coord_y),
        .i_first_city (i_first_city),
        .i_last_city  (i_last_city),
        .o_cmd_push   (cmd_push),
        .i_cmd_full   (cmd_full),
        .o_cmd_flags  (fr_flags),
        .o_cmd_dx     (fr_dx),
        .o_cmd_dy     (fr_dy)
    );

    tle_queue #(
        .WIDTH (CMD_W),
        .DEPTH (CMD_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (q_in),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_data  (q_out),
        .o_empty (cmd_empty)
    );

    tle_back #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_empty   (cmd_empty),
        .i_cmd_flags   (bk_flags),
        .i_cmd_dx      (bk_dx),
        .i_cmd_dy      (bk_dy),
        .o_cmd_pop     (cmd_pop),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_tour_length (o_tour_length),
        .o_leg_count   (o_leg_count)
    );

endmodule

FILE: verif/tour_length_evaluator_tb.sv
module tour_length_evaluator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tle_pkg::*;

    localparam int IDLE_LIMIT   = 3000;  // cycles without any transfer
    localparam int LONG_HOLD    = 500;
    localparam int DRAIN_CYCLES = 200;   // settle time after the last expected result is checked
    localparam int RANDOM_ITEMS = 700;

    typedef struct packed {
        logic [LEN_W-1:0]  length;
        logic [LEGS_W-1:0] legs;
    } t_tour_result;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  push;
    logic                  full;
    logic                  i_mode;
    logic [CITY_W-1:0]     i_city;
    logic [COORD_W-1:0]    i_coord_x;
    logic [COORD_W-1:0]    i_coord_y;
    logic                  i_first_city;
    logic                  i_last_city;
    logic                  empty;
    logic                  pop;
    logic [LEN_W-1:0]      o_tour_length;
    logic [LEGS_W-1:0]     o_leg_count;

    // tour model state
    logic [COORD_W-1:0]    city_x [MAX_CITIES_DEF];
    logic [COORD_W-1:0]    city_y [MAX_CITIES_DEF];
    logic [COORD_W-1:0]    prev_x = '0;
    logic [COORD_W-1:0]    prev_y = '0;
    logic [LEN_W-1:0]      run_length = '0;
    logic [LEGS_W-1:0]     run_legs = '0;
    t_tour_result          tour_results_due[$];

    bit                    city_loaded [MAX_CITIES_DEF];
    int                    err_cnt = 0;
    int                    burst_left = 0;
    bit                    sender_steady = 0;
    bit                    hold_request = 0;
    int                    idle_cycles = 0;

    tour_length_evaluator u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_mode        (i_mode),
        .i_city        (i_city),
        .i_coord_x     (i_coord_x),
        .i_coord_y     (i_coord_y),
        .i_first_city  (i_first_city),
        .i_last_city   (i_last_city),
        .empty         (empty),
        .pop           (pop),
        .o_tour_length (o_tour_length),
        .o_leg_count   (o_leg_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // floor(sqrt(d2) * 2^FRAC_BITS), built one root bit at a time from the top
    function automatic logic [LEN_W-1:0] leg_root(input logic [COORD_W-1:0] dx,
                                                  input logic [COORD_W-1:0] dy);
        longint unsigned dxl;
        longint unsigned dyl;
        longint unsigned rad;
        longint unsigned cand;
        longint unsigned root;
        dxl  = 64'(dx);
        dyl  = 64'(dy);
        rad  = (dxl * dxl + dyl * dyl) << (2 * FRAC_BITS_DEF);
        root = 0;
        for (int b = LEN_W - 1; b >= 0; b--) begin
            cand = root | (64'd1 << b);
            if (cand * cand <= rad) begin
                root = cand;
            end
        end
        return root[LEN_W-1:0];
    endfunction

    function automatic void advance_tour_model(input logic mode,
                                               input logic [CITY_W-1:0] city,
                                               input logic [COORD_W-1:0] x,
                                               input logic [COORD_W-1:0] y,
                                               input logic first,
                                               input logic last);
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
        logic [COORD_W-1:0] dx;
        logic [COORD_W-1:0] dy;
        logic [LEN_W:0]     total;
        t_tour_result       res;
        if (mode == MODE_LOAD) begin
            city_x[city] = x;
            city_y[city] = y;
            return;
        end
        cx = city_x[city];
        cy = city_y[city];
        if (first) begin
            run_length = '0;
            run_legs   = '0;
        end else begin
            dx = (cx >= prev_x) ? cx - prev_x : prev_x - cx;
            dy = (cy >= prev_y) ? cy - prev_y : prev_y - cy;
            total = {1'b0, run_length} + {1'b0, leg_root(dx, dy)};
            run_length = (total > SUM_MAX) ? SUM_MAX : total[LEN_W-1:0];
            if (run_legs != LEGS_MAX) begin
                run_legs = run_legs + 1'b1;
            end
        end
        prev_x = cx;
        prev_y = cy;
        if (last) begin
            res.length = run_length;
            res.legs   = run_legs;
            tour_results_due.push_back(res);
        end
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t ns mismatch: %s", $time, what);
        err_cnt++;
    endtask

    // Called at a falling edge; returns at a falling edge after the transfer.
    task automatic send_item(input logic mode, input logic [CITY_W-1:0] city,
                             input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                             input logic first, input logic last);
        int gap;
        if (burst_left <= 0) begin
            gap = sender_steady ? 0 :
                  ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 15));
            push = 1'b0;
            repeat (gap) @(negedge i_clk);
            burst_left = $urandom_range(1, 40);
        end
        push         = 1'b1;
        i_mode       = mode;
        i_city       = city;
        i_coord_x    = x;
        i_coord_y    = y;
        i_first_city = first;
        i_last_city  = last;
        forever begin
            @(posedge i_clk);
            if (!full) break;
        end
        advance_tour_model(mode, city, x, y, first, last);
        if (mode == MODE_LOAD) begin
            city_loaded[city] = 1'b1;
        end
        burst_left--;
        @(negedge i_clk);
        push = 1'b0;
    endtask

    function automatic logic [CITY_W-1:0] pick_loaded_city();
        logic [CITY_W-1:0] c;
        do begin
            c = CITY_W'($urandom_range(0, MAX_CITIES_DEF - 1));
        end while (!city_loaded[c]);
        return c;
    endfunction

    task automatic load_city(input logic [CITY_W-1:0] city, input logic [COORD_W-1:0] x,
                             input logic [COORD_W-1:0] y);
        send_item(MODE_LOAD, city, x, y, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    task automatic tour_step(input logic [CITY_W-1:0] city, input logic first,
                             input logic last);
        send_item(MODE_TOUR, city, COORD_W'($urandom), COORD_W'($urandom), first, last);
    endtask

    task automatic test_directed();
        load_city(4'd0, 8'd0, 8'd0);
        load_city(4'd15, 8'd255, 8'd255);
        load_city(4'd1, 8'd255, 8'd0);
        load_city(4'd2, 8'd0, 8'd255);
        // no first item after reset: leg measured from the origin
        tour_step(4'd15, 1'b0, 1'b1);
        // first and last together
        tour_step(4'd0, 1'b1, 1'b1);
        tour_step(4'd0, 1'b1, 1'b0);
        tour_step(4'd1, 1'b0, 1'b0);
        tour_step(4'd1, 1'b0, 1'b0);   // zero-length leg
        tour_step(4'd2, 1'b0, 1'b0);
        tour_step(4'd15, 1'b0, 1'b1);
        // state kept after the last city, so this keeps adding
        tour_step(4'd0, 1'b0, 1'b1);
        // load with both flags set must not produce a result
        send_item(MODE_LOAD, 4'd3, 8'hA5, 8'h5A, 1'b1, 1'b1);
        tour_step(4'd3, 1'b1, 1'b0);
        tour_step(4'd0, 1'b0, 1'b1);
    endtask

    // Corner to corner legs: the sum clips after about 23, the leg count at 31.
    task automatic test_saturation();
        tour_step(4'd0, 1'b1, 1'b0);
        for (int i = 0; i < 35; i++) begin
            tour_step((i % 2 == 0) ? 4'd15 : 4'd0, 1'b0, i == 34);
        end
    endtask

    task automatic test_random_tours(input int n_items);
        int sent;
        int len;
        int pick;
        sent = 0;
        for (int c = 0; c < MAX_CITIES_DEF; c++) begin
            load_city(CITY_W'(c), COORD_W'($urandom), COORD_W'($urandom));
            sent++;
        end
        while (sent < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
                load_city(CITY_W'($urandom_range(0, MAX_CITIES_DEF - 1)),
                          COORD_W'($urandom), COORD_W'($urandom));
                sent++;
            end else if (pick < 85) begin
                len = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 36)
                                                   : $urandom_range(1, 8);
                for (int i = 0; i < len; i++) begin
                    tour_step(pick_loaded_city(), i == 0, i == len - 1);
                end
                sent += len;
            end else begin
                // stray tour item with arbitrary flags
                tour_step(pick_loaded_city(), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
                sent++;
            end
        end
    endtask

    // Receiver holds off while short tours keep coming, so the result register
    // stays full, the command queue backs up and full rises.
    task automatic test_backpressure();
        hold_request  = 1'b1;
        sender_steady = 1'b1;
        for (int i = 0; i < 48; i++) begin
            tour_step(pick_loaded_city(), 1'b1, 1'b1);
        end
        sender_steady = 1'b0;
    endtask

    initial begin
        push         = 1'b0;
        i_mode       = MODE_LOAD;
        i_city       = '0;
        i_coord_x    = '0;
        i_coord_y    = '0;
        i_first_city = 1'b0;
        i_last_city  = 1'b0;
        i_rst_n      = 1'b0;
        for (int c = 0; c < MAX_CITIES_DEF; c++) begin
            city_x[c]      = '0;
            city_y[c]      = '0;
            city_loaded[c] = 1'b0;
        end
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_saturation();
        test_random_tours(RANDOM_ITEMS);
        test_backpressure();

        while (tour_results_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // result side: shifting stall pattern plus a long hold-off when the backpressure test asks for one
    initial begin : receiver
        int stall_left;
        int mode_left;
        int recv_mode;
        stall_left = 0;
        mode_left  = 0;
        recv_mode  = 0;
        pop        = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                stall_left   = LONG_HOLD;
            end
            if (mode_left <= 0) begin
                recv_mode = $urandom_range(0, 2);
                mode_left = $urandom_range(50, 200);
            end
            mode_left--;
            if (stall_left > 0) begin
                stall_left--;
                pop = 1'b0;
            end else begin
                case (recv_mode)
                    0: pop = 1'b1;
                    1: pop = 1'($urandom_range(0, 1));
                    default: pop = ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        t_tour_result due;
        if (i_rst_n && pop && !empty) begin
            if (tour_results_due.size() == 0) begin
                report_mismatch($sformatf("unexpected result length %0d legs %0d",
                                          o_tour_length, o_leg_count));
            end else begin
                due = tour_results_due.pop_front();
                if (o_tour_length !== due.length) begin
                    report_mismatch($sformatf("tour_length got %0d want %0d",
                                              o_tour_length, due.length));
                end
                if (o_leg_count !== due.legs) begin
                    report_mismatch($sformatf("leg_count got %0d want %0d",
                                              o_leg_count, due.legs));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((push && !full) || (pop && !empty)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no transfer in %0d cycles", IDLE_LIMIT);
                $display("[FAIL] regression broken");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

endmodule
